[design/ces_pkg.sv]
// Shared types for the concatenating exchange sorter.
// No dependencies; every other file of the block but ces_checker refers to this package by scoped names.
`timescale 1ns / 1ps

package ces_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [7:0] {
        ST_LOAD    = 8'b0000_0001,
        ST_COPY    = 8'b0000_0010,
        ST_SORT_P  = 8'b0000_0100,
        ST_SORT_LD = 8'b0000_1000,
        ST_SORT_Q  = 8'b0001_0000,
        ST_SORT_WP = 8'b0010_0000,
        ST_OUT_RD  = 8'b0100_0000,
        ST_OUT_WT  = 8'b1000_0000
    } state_t;

    // One result beat offered by the sequencer to the output register.
    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] value;
        logic                     final_res;
    } out_beat_t;

    // Result of one compare-exchange step.
    typedef struct packed {
        logic                     swap;
        logic signed [DATA_W-1:0] held;
        logic signed [DATA_W-1:0] evicted;
    } cmp_res_t;

endpackage

[design/ces_cmp.sv]
// Compare-exchange unit shared by every step of the sort.
// Depends on ces_pkg for the data width and the result struct.
`timescale 1ns / 1ps

module ces_cmp
(
    input  logic signed [ces_pkg::DATA_W-1:0] cur,
    input  logic signed [ces_pkg::DATA_W-1:0] cand,
    output ces_pkg::cmp_res_t                 res
);

    // Equal values are not swapped.
    always_comb
    begin
        res.swap    = cur > cand;
        res.held    = res.swap ? cand : cur;
        res.evicted = res.swap ? cur : cand;
    end

endmodule

[design/ces_seq.sv]
// Sequencer of the sorter: list memories, work buffer, load, copy, sort and readout.
// Depends on ces_pkg and on the compare-exchange unit ces_cmp.
`timescale 1ns / 1ps

module ces_seq
#(
    parameter int LIST_DEPTH = 8
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [ces_pkg::DATA_W-1:0] in_value,
    input  logic                              in_second,
    input  logic                              in_last,
    input  logic                              out_space,
    output ces_pkg::out_beat_t                beat
);

    localparam int WD  = 2 * LIST_DEPTH;
    localparam int CW  = $clog2(LIST_DEPTH + 1);
    localparam int LAW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int WAW = $clog2(WD);
    localparam int TW  = $clog2(WD + 1);

    logic signed [ces_pkg::DATA_W-1:0] w_mem [WD];
    logic signed [ces_pkg::DATA_W-1:0] b_mem [LIST_DEPTH];

    ces_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   ca_reg, ca_next;
    logic [CW-1:0]   cb_reg, cb_next;
    logic [TW-1:0]   total_reg, total_next;
    logic [TW-1:0]   cnt_reg, cnt_next;
    logic [WAW-1:0]  q_reg, q_next;
    logic            cwv_reg, cwv_next;
    logic [WAW-1:0]  cw_addr_reg, cw_addr_next;
    logic signed [ces_pkg::DATA_W-1:0] cur_reg, cur_next;
    logic signed [ces_pkg::DATA_W-1:0] w_rdata_reg;
    logic signed [ces_pkg::DATA_W-1:0] b_rdata_reg;

    logic                              w_we;
    logic [WAW-1:0]                    w_waddr;
    logic signed [ces_pkg::DATA_W-1:0] w_wdata;
    logic [WAW-1:0]                    w_raddr;
    logic                              b_we;
    logic [LAW-1:0]                    b_raddr;

    logic          accept;
    logic          a_full;
    logic          b_full;
    logic [CW-1:0] ca_load;
    logic [CW-1:0] cb_load;
    logic [TW-1:0] total_load;
    logic          is_final;

    ces_pkg::cmp_res_t cmp_res;

    ces_cmp u_cmp
    (
        .cur  (cur_reg),
        .cand (w_rdata_reg),
        .res  (cmp_res)
    );

    assign in_ready   = (state_reg == ces_pkg::ST_LOAD);
    assign accept     = in_valid && in_ready;
    assign a_full     = (ca_reg == CW'(LIST_DEPTH));
    assign b_full     = (cb_reg == CW'(LIST_DEPTH));
    assign ca_load    = (!in_second && !a_full) ? ca_reg + CW'(1) : ca_reg;
    assign cb_load    = (in_second && !b_full) ? cb_reg + CW'(1) : cb_reg;
    assign total_load = TW'(ca_load) + TW'(cb_load);
    assign is_final   = (cnt_reg == total_reg - TW'(1));
    assign b_we       = accept && in_second && !b_full;
    assign b_raddr    = cnt_reg[LAW-1:0];

    always_comb
    begin
        state_next   = state_reg;
        ca_next      = ca_reg;
        cb_next      = cb_reg;
        total_next   = total_reg;
        cnt_next     = cnt_reg;
        q_next       = q_reg;
        cwv_next     = 1'b0;
        cw_addr_next = cw_addr_reg;
        cur_next     = cur_reg;
        w_we         = 1'b0;
        w_waddr      = WAW'(ca_reg);
        w_wdata      = in_value;
        w_raddr      = cnt_reg[WAW-1:0];
        beat.valid     = 1'b0;
        beat.value     = w_rdata_reg;
        beat.final_res = is_final;

        case (state_reg)
            ces_pkg::ST_LOAD:
            begin
                if (accept)
                begin
                    w_we    = !in_second && !a_full;
                    ca_next = ca_load;
                    cb_next = cb_load;
                    if (in_last)
                    begin
                        total_next = total_load;
                        cnt_next   = '0;
                        if (cb_load != '0)
                            state_next = ces_pkg::ST_COPY;
                        else if (total_load < TW'(2))
                            state_next = ces_pkg::ST_OUT_RD;
                        else
                            state_next = ces_pkg::ST_SORT_P;
                    end
                end
            end

            ces_pkg::ST_COPY:
            begin
                // List B is read one entry a cycle and each entry lands behind list A in the cycle after its read.
                w_we    = cwv_reg;
                w_waddr = cw_addr_reg;
                w_wdata = b_rdata_reg;
                if (cnt_reg < TW'(cb_reg))
                begin
                    cnt_next     = cnt_reg + TW'(1);
                    cwv_next     = 1'b1;
                    cw_addr_next = WAW'(ca_reg) + cnt_reg[WAW-1:0];
                end
                else if (!cwv_reg)
                begin
                    cnt_next = '0;
                    if (total_reg < TW'(2))
                        state_next = ces_pkg::ST_OUT_RD;
                    else
                        state_next = ces_pkg::ST_SORT_P;
                end
            end

            ces_pkg::ST_SORT_P:
            begin
                state_next = ces_pkg::ST_SORT_LD;
            end

            ces_pkg::ST_SORT_LD:
            begin
                // The entry at position p becomes the running candidate.
                cur_next   = w_rdata_reg;
                w_raddr    = cnt_reg[WAW-1:0] + WAW'(1);
                q_next     = cnt_reg[WAW-1:0] + WAW'(1);
                state_next = ces_pkg::ST_SORT_Q;
            end

            ces_pkg::ST_SORT_Q:
            begin
                w_we    = cmp_res.swap;
                w_waddr = q_reg;
                w_wdata = cmp_res.evicted;
                cur_next = cmp_res.held;
                w_raddr  = q_reg + WAW'(1);
                q_next   = q_reg + WAW'(1);
                if (TW'(q_reg) == total_reg - TW'(1))
                    state_next = ces_pkg::ST_SORT_WP;
            end

            ces_pkg::ST_SORT_WP:
            begin
                w_we     = 1'b1;
                w_waddr  = cnt_reg[WAW-1:0];
                w_wdata  = cur_reg;
                w_raddr  = cnt_reg[WAW-1:0] + WAW'(1);
                cnt_next = cnt_reg + TW'(1);
                if (cnt_reg + TW'(1) == total_reg - TW'(1))
                begin
                    cnt_next   = '0;
                    state_next = ces_pkg::ST_OUT_RD;
                end
                else
                begin
                    state_next = ces_pkg::ST_SORT_LD;
                end
            end

            ces_pkg::ST_OUT_RD:
            begin
                state_next = ces_pkg::ST_OUT_WT;
            end

            ces_pkg::ST_OUT_WT:
            begin
                beat.valid = 1'b1;
                if (out_space)
                begin
                    cnt_next = cnt_reg + TW'(1);
                    w_raddr  = cnt_reg[WAW-1:0] + WAW'(1);
                    if (is_final)
                    begin
                        ca_next    = '0;
                        cb_next    = '0;
                        state_next = ces_pkg::ST_LOAD;
                    end
                end
            end

            default:
            begin
                state_next = ces_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ces_pkg::ST_LOAD;
            ca_reg    <= '0;
            cb_reg    <= '0;
            total_reg <= '0;
            cnt_reg   <= '0;
            cwv_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ca_reg    <= ca_next;
            cb_reg    <= cb_next;
            total_reg <= total_next;
            cnt_reg   <= cnt_next;
            cwv_reg   <= cwv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg       <= q_next;
        cw_addr_reg <= cw_addr_next;
        cur_reg     <= cur_next;
    end

    always_ff @(posedge clk)
    begin
        if (w_we)
            w_mem[w_waddr] <= w_wdata;
        w_rdata_reg <= w_mem[w_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
            b_mem[cb_reg[LAW-1:0]] <= in_value;
        b_rdata_reg <= b_mem[b_raddr];
    end

endmodule

[design/concat_exchange_sorter.sv]
// Top level of the concatenating exchange sorter: sequencer plus output register.
// Depends on ces_pkg and ces_seq.
//
// Usage: elements arrive on the slave stream, one beat per cycle while s_tready is high.
// s_tuser selects the list (0 = A, 1 = B); an element sent to a full list is dropped.
// A beat with s_tlast set is stored like any other and then starts the run: list B is
// copied behind list A in the work buffer, the buffer is sorted ascending by exchange
// sort, and the sorted run leaves on the master stream with m_tlast on its final beat.
// The sort time is set by the single compare-exchange unit and the one read and one
// write port of the work buffer. Readout then moves one beat per cycle unless stalled.
// s_tready stays low from the last beat until the final result has entered the output
// register; the next run may load while that beat still waits. A stalled receiver
// simply holds the sequencer at its current beat, nothing is lost.
// Reset empties both lists and the output register; memory contents are not cleared.
`timescale 1ns / 1ps

module concat_exchange_sorter
#(
    parameter int LIST_DEPTH = 8
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic signed [ces_pkg::DATA_W-1:0] s_tdata,  // [31:0] value
    input  logic                              s_tuser,  // [0] to_second_list
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic signed [ces_pkg::DATA_W-1:0] m_tdata,  // [31:0] sorted_value
    output logic                              m_tlast
);

    ces_pkg::out_beat_t beat;
    logic               out_space;

    logic                              out_valid_reg;
    logic signed [ces_pkg::DATA_W-1:0] out_data_reg;
    logic                              out_last_reg;

    ces_seq #(.LIST_DEPTH(LIST_DEPTH)) u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_value  (s_tdata),
        .in_second (s_tuser),
        .in_last   (s_tlast),
        .out_space (out_space),
        .beat      (beat)
    );

    assign out_space = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (beat.valid && out_space)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (beat.valid && out_space)
        begin
            out_data_reg <= beat.value;
            out_last_reg <= beat.final_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

[design/ces_checker.sv]
// Port-level checks for concat_exchange_sorter, attached by the bind at the end.
// Depends only on the ports of the top level.
`timescale 1ns / 1ps

module ces_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);

    // A stalled result beat holds its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // A non-final result beat can only be pending while a run is being read out.
    a_no_load_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input accepted in the middle of a sorted run");

    // The last beat always starts a run, since it is stored first.
    a_last_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("run did not start after the last beat");

    // Ordinary beats keep the block loading.
    a_load_continues: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tlast |=> s_tready)
        else $error("loading stopped without a last beat");

endmodule

bind concat_exchange_sorter ces_checker u_ces_checker (.*);

[verif/tb_top.sv]
// Self-checking testbench for concat_exchange_sorter: loads two lists, sorts, checks the run.
// Depends on ces_pkg and the design files; a scoreboard class predicts each sorted run.
`timescale 1ns / 1ps

module tb_top;

    localparam int W          = ces_pkg::DATA_W;
    localparam int LIST_DEPTH = 8;
    localparam int ITEM_GOAL  = 470;

    class sort_scoreboard;
        typedef struct {
            logic signed [W-1:0] value;
            logic                final_res;
        } sorted_beat_t;

        logic signed [W-1:0] list_a[$];
        logic signed [W-1:0] list_b[$];
        sorted_beat_t        expected_q[$];
        int                  depth;
        int                  errors;

        function new(int list_depth);
            depth  = list_depth;
            errors = 0;
        endfunction

        // Stores the element unless its list is full and, on a last beat, predicts the whole sorted run.
        function void note_element(logic signed [W-1:0] value, logic to_b, logic last_flag);
            logic signed [W-1:0] work[$];
            logic signed [W-1:0] tmp;
            sorted_beat_t        beat;
            if (to_b)
            begin
                if (list_b.size() < depth)
                    list_b.push_back(value);
            end
            else
            begin
                if (list_a.size() < depth)
                    list_a.push_back(value);
            end
            if (!last_flag)
                return;
            work = {list_a, list_b};
            for (int p = 0; p < work.size(); p++)
            begin
                for (int q = p + 1; q < work.size(); q++)
                begin
                    if (work[p] > work[q])
                    begin
                        tmp     = work[p];
                        work[p] = work[q];
                        work[q] = tmp;
                    end
                end
            end
            for (int p = 0; p < work.size(); p++)
            begin
                beat.value     = work[p];
                beat.final_res = (p == work.size() - 1);
                expected_q.push_back(beat);
            end
            list_a.delete();
            list_b.delete();
        endfunction

        function void check_result(logic signed [W-1:0] value, logic final_res);
            sorted_beat_t beat;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result beat: expected none, actual value %0d last %0b",
                         $time, value, final_res);
                errors++;
                return;
            end
            beat = expected_q.pop_front();
            if (value !== beat.value)
            begin
                $display("%0t: sorted_value mismatch: expected %0d, actual %0d",
                         $time, beat.value, value);
                errors++;
            end
            if (final_res !== beat.final_res)
            begin
                $display("%0t: m_tlast mismatch: expected %0b, actual %0b",
                         $time, beat.final_res, final_res);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic signed [W-1:0] s_tdata  = '0;
    logic                s_tuser  = 1'b0;
    logic                s_tlast  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic signed [W-1:0] m_tdata;
    logic                m_tlast;

    logic                steady   = 1'b0;
    int                  items_sent = 0;
    sort_scoreboard      sorted_sb;

    concat_exchange_sorter #(
        .LIST_DEPTH (LIST_DEPTH)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        m_tready <= steady || ($urandom_range(99) >= 12);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sorted_sb.note_element(s_tdata, s_tuser, s_tlast);
            if (m_tvalid && m_tready)
                sorted_sb.check_result(m_tdata, m_tlast);
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat was taken.
    task automatic send_beat(logic signed [W-1:0] value, logic to_b, logic last_flag);
        if (!steady)
        begin
            while ($urandom_range(99) < 12)
            begin
                s_tvalid <= 1'b0;
                @(negedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= to_b;
        s_tlast  <= last_flag;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        items_sent++;
    endtask

    // Drops s_tvalid and waits until no result is pending, so the next beat starts on a later edge.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (sorted_sb.pending() > 0);
    endtask

    initial
    begin
        int                  run_len;
        int                  mode;
        logic                to_b;
        logic signed [W-1:0] value;

        sorted_sb = new(LIST_DEPTH);
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Single-element run holding the most negative value.
        send_beat(32'sh8000_0000, 1'b0, 1'b1);

        // Both extremes, zero and minus one spread across the two lists.
        send_beat(32'sh7FFF_FFFF, 1'b0, 1'b0);
        send_beat(-32'sd1,        1'b0, 1'b0);
        send_beat(32'sd0,         1'b0, 1'b0);
        send_beat(32'sh8000_0000, 1'b1, 1'b0);
        send_beat(32'sd1,         1'b1, 1'b1);

        // Equal elements in both lists.
        send_beat(32'sd5, 1'b0, 1'b0);
        send_beat(32'sd5, 1'b1, 1'b1);

        // Overfill list A, fill list B, and end on a last beat that list B drops.
        for (int i = 0; i < LIST_DEPTH + 1; i++)
            send_beat((i % 2) ? 32'sh7FFF_FFFF - i : 32'sh8000_0000 + i, 1'b0, 1'b0);
        for (int i = 0; i < LIST_DEPTH; i++)
            send_beat($urandom(), 1'b1, 1'b0);
        send_beat(32'sd0, 1'b1, 1'b1);

        while (items_sent < ITEM_GOAL)
        begin
            // A stretch with no idling on either side.
            steady <= (items_sent >= 150 && items_sent < 260);

            // Hold off until the block has emptied completely, for every run that starts in this window.
            if (items_sent >= 320 && items_sent < 340)
                drain_results();

            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5, 6: run_len = $urandom_range(1, LIST_DEPTH);
                7, 8:                run_len = $urandom_range(LIST_DEPTH + 1, 2 * LIST_DEPTH);
                default:             run_len = $urandom_range(2 * LIST_DEPTH + 1,
                                                              2 * LIST_DEPTH + 4);
            endcase
            mode = $urandom_range(3);

            for (int i = 0; i < run_len; i++)
            begin
                case (mode)
                    0:       to_b = 1'b0;
                    1:       to_b = 1'b1;
                    default: to_b = $urandom_range(1);
                endcase
                case ($urandom_range(9))
                    0:       value = 32'sh8000_0000;
                    1:       value = 32'sh7FFF_FFFF;
                    2:       value = 32'sd0;
                    3:       value = -32'sd1;
                    4, 5:    value = $signed($urandom_range(15)) - 32'sd8;
                    default: value = $urandom();
                endcase
                send_beat(value, to_b, i == run_len - 1);
            end
        end

        drain_results();
        repeat (200) @(negedge clk);
        if (sorted_sb.errors == 0 && sorted_sb.pending() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("%0t: timeout with %0d results still expected", $time, sorted_sb.pending());
        $display("Test completed with failures");
        $finish;
    end

endmodule

[filelist.f]
design/ces_pkg.sv
design/ces_cmp.sv
design/ces_seq.sv
design/concat_exchange_sorter.sv
design/ces_checker.sv
verif/tb_top.sv
